>>> hw/rtl/slsr_pkg.sv
package slsr_pkg;

  // default sizes
  localparam int QUEUE_DEPTH   = 16;
  localparam int KEY_BYTES_MAX = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SLOTS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SLOTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_PARAM  = 2'd2;
  localparam int CFG_DATA_W = 8;

  // configuration reset values
  localparam logic [7:0] LEFT_SLOTS_RST  = 8'd64;
  localparam logic [7:0] RIGHT_SLOTS_RST = 8'd64;
  localparam logic [7:0] SIDE_PARAM_RST  = 8'd0;

  // item actions
  localparam logic [1:0] ACT_FRAME     = 2'd0;
  localparam logic [1:0] ACT_TASK_DONE = 2'd1;
  localparam logic [1:0] ACT_KEY_LOAD  = 2'd2;
  localparam logic [1:0] ACT_POP       = 2'd3;

  // link opcodes and reply codes
  localparam logic [7:0] OP_KEY_REQ     = 8'hC1;
  localparam logic [7:0] HDR_KEY_STATE  = 8'hC2;
  localparam logic [7:0] OP_TASK_FIRST  = 8'hD1;
  localparam logic [7:0] OP_TASK_LAST   = 8'hD4;
  localparam logic [7:0] OP_IDLE_CHECK  = 8'hDF;
  localparam logic [7:0] OP_KEY_CHANGE  = 8'hE1;
  localparam logic [7:0] OP_PARAM_CHANGE = 8'hE2;
  localparam logic [7:0] RSP_ACK        = 8'hF0;
  localparam logic [7:0] RSP_NACK       = 8'hF1;

  // result kinds
  localparam logic KIND_TX  = 1'b0;
  localparam logic KIND_POP = 1'b1;

  // queue entry layout: {value, slot_or_param, op}
  localparam int ENTRY_W = 24;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] frame_length;
    logic [7:0] command;
    logic [7:0] first_arg;
    logic [7:0] second_arg;
    logic [3:0] key_byte_index;
    logic [7:0] key_byte_value;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       entry_present;
    logic [7:0] entry_op;
    logic [7:0] entry_slot_or_param;
    logic [7:0] entry_value;
    logic [7:0] pending_task;
    logic       on_right;
    logic       queue_dropped;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SEND
  } state_e;

  // what an item needs from the controller
  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_REPLY,
    CLS_POP
  } item_class_e;

  typedef struct packed {
    logic take;
    logic pop_load;
    logic key_next;
  } ctrl_cmd_t;

  typedef struct packed {
    item_class_e cls;
    logic        keys_more;
  } dp_status_t;

endpackage

>>> hw/rtl/slsr_if.sv
interface slsr_in_if;
  logic                valid;
  logic                ready;
  slsr_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface slsr_out_if;
  logic                valid;
  logic                ready;
  slsr_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/slsr_ram.sv
module slsr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/slsr_ctrl.sv
module slsr_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  slsr_pkg::dp_status_t   status_i,
  output slsr_pkg::ctrl_cmd_t    cmd_o
);

  slsr_pkg::state_e state_q, state_d;
  logic take;

  assign take = in_valid_i && (state_q == slsr_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      slsr_pkg::ST_IDLE: begin
        if (take) begin
          case (status_i.cls)
            slsr_pkg::CLS_REPLY: state_d = slsr_pkg::ST_SEND;
            slsr_pkg::CLS_POP:   state_d = slsr_pkg::ST_POP;
            default:             state_d = slsr_pkg::ST_IDLE;
          endcase
        end
      end
      slsr_pkg::ST_POP: begin
        state_d = slsr_pkg::ST_SEND;
      end
      slsr_pkg::ST_SEND: begin
        if (out_ready_i && !status_i.keys_more) begin
          state_d = slsr_pkg::ST_IDLE;
        end
      end
      default: state_d = slsr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    cmd_o.take     = 1'b0;
    cmd_o.pop_load = 1'b0;
    cmd_o.key_next = 1'b0;
    case (state_q)
      slsr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      slsr_pkg::ST_POP: begin
        cmd_o.pop_load = 1'b1;
      end
      slsr_pkg::ST_SEND: begin
        out_valid_o    = 1'b1;
        cmd_o.key_next = out_ready_i && status_i.keys_more;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slsr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/slsr_dp.sv
module slsr_dp #(
  parameter int QueueDepth  = slsr_pkg::QUEUE_DEPTH,
  parameter int KeyBytesMax = slsr_pkg::KEY_BYTES_MAX
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [slsr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [slsr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  slsr_pkg::in_item_t                  item_i,
  input  slsr_pkg::ctrl_cmd_t                 cmd_i,
  output slsr_pkg::dp_status_t                status_o,
  output slsr_pkg::out_item_t                 result_o
);

  localparam int QW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCW = $clog2(QueueDepth + 1);
  localparam int KIW = (KeyBytesMax > 1) ? $clog2(KeyBytesMax) : 1;
  localparam int KCW = $clog2(KeyBytesMax + 1);

  // configuration
  logic [7:0] left_slots_q, right_slots_q, side_param_q;

  // block state
  logic [7:0]     task_q;
  logic [7:0]     key_store_q [KeyBytesMax];
  logic [KCW-1:0] key_count_q;
  logic           right_q;
  logic [QW-1:0]  rd_ptr_q, wr_ptr_q;
  logic [QCW-1:0] cnt_q;
  logic [KCW-1:0] key_idx_q;
  logic           streaming_q;
  slsr_pkg::out_item_t out_q, out_d;

  // decode
  logic           frame_ok, is_idle, is_task, is_key_req, is_change;
  logic           q_full, q_empty;
  logic [8:0]     slot_sum;
  logic [5:0]     slot_bytes;
  logic [KCW-1:0] key_count_d;
  logic           ram_we, ram_re;
  logic [slsr_pkg::ENTRY_W-1:0] ram_rdata;
  logic [7:0]     pop_op, pop_arg, pop_val;
  logic           right_d;
  logic [QW-1:0]  wr_ptr_inc, rd_ptr_inc;

  assign frame_ok   = (item_i.action == slsr_pkg::ACT_FRAME) && (item_i.frame_length != 5'd0);
  assign is_idle    = frame_ok && (item_i.command == slsr_pkg::OP_IDLE_CHECK);
  assign is_task    = frame_ok && (item_i.command >= slsr_pkg::OP_TASK_FIRST)
                      && (item_i.command <= slsr_pkg::OP_TASK_LAST);
  assign is_key_req = frame_ok && (item_i.command == slsr_pkg::OP_KEY_REQ);
  assign is_change  = frame_ok && ((item_i.command == slsr_pkg::OP_KEY_CHANGE)
                      || (item_i.command == slsr_pkg::OP_PARAM_CHANGE));

  assign q_full  = (cnt_q == QCW'(QueueDepth));
  assign q_empty = (cnt_q == '0);

  always_comb begin
    status_o.cls = slsr_pkg::CLS_NONE;
    if (is_idle || is_task || is_key_req || is_change) begin
      status_o.cls = slsr_pkg::CLS_REPLY;
    end else if (item_i.action == slsr_pkg::ACT_POP) begin
      status_o.cls = q_empty ? slsr_pkg::CLS_REPLY : slsr_pkg::CLS_POP;
    end
    status_o.keys_more = streaming_q && (key_idx_q < key_count_q);
  end

  // key byte count for the current side, saturated
  assign slot_sum   = {1'b0, (right_q ? right_slots_q : left_slots_q)} + 9'd7;
  assign slot_bytes = slot_sum[8:3];
  assign key_count_d = (slot_bytes > 6'(KeyBytesMax)) ? KCW'(KeyBytesMax)
                                                      : KCW'(slot_bytes);

  // queue memory
  assign ram_we = cmd_i.take && is_change && !q_full;
  assign ram_re = cmd_i.take && (item_i.action == slsr_pkg::ACT_POP) && !q_empty;

  assign wr_ptr_inc = (wr_ptr_q == QW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign rd_ptr_inc = (rd_ptr_q == QW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;

  slsr_ram #(
    .Width(slsr_pkg::ENTRY_W),
    .Depth(QueueDepth)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_ptr_q),
    .wdata_i({item_i.second_arg, item_i.first_arg, item_i.command}),
    .re_i   (ram_re),
    .raddr_i(rd_ptr_q),
    .rdata_o(ram_rdata)
  );

  assign pop_op  = ram_rdata[7:0];
  assign pop_arg = ram_rdata[15:8];
  assign pop_val = ram_rdata[23:16];
  // a popped side parameter change sets the board half: right when its value is zero
  assign right_d = ((pop_op == slsr_pkg::OP_PARAM_CHANGE) && (pop_arg == side_param_q))
                   ? (pop_val == 8'd0) : right_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_slots_q  <= slsr_pkg::LEFT_SLOTS_RST;
      right_slots_q <= slsr_pkg::RIGHT_SLOTS_RST;
      side_param_q  <= slsr_pkg::SIDE_PARAM_RST;
      task_q        <= '0;
      key_count_q   <= '0;
      right_q       <= 1'b0;
      rd_ptr_q      <= '0;
      wr_ptr_q      <= '0;
      cnt_q         <= '0;
      key_idx_q     <= '0;
      streaming_q   <= 1'b0;
      for (int i = 0; i < KeyBytesMax; i++) begin
        key_store_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          slsr_pkg::CFG_LEFT_SLOTS:  left_slots_q  <= cfg_wdata_i;
          slsr_pkg::CFG_RIGHT_SLOTS: right_slots_q <= cfg_wdata_i;
          slsr_pkg::CFG_SIDE_PARAM:  side_param_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.take) begin
        streaming_q <= is_key_req;
        key_idx_q   <= '0;
        if (is_task) begin
          task_q <= item_i.command;
        end
        if (item_i.action == slsr_pkg::ACT_TASK_DONE) begin
          task_q <= '0;
        end
        if (item_i.action == slsr_pkg::ACT_KEY_LOAD) begin
          key_count_q <= key_count_d;
          for (int i = 0; i < KeyBytesMax; i++) begin
            if ({1'b0, item_i.key_byte_index} == 5'(i)) begin
              key_store_q[i] <= item_i.key_byte_value;
            end
          end
        end
        if (ram_we) begin
          wr_ptr_q <= wr_ptr_inc;
          cnt_q    <= cnt_q + 1'b1;
        end
        if (ram_re) begin
          rd_ptr_q <= rd_ptr_inc;
          cnt_q    <= cnt_q - 1'b1;
        end
      end
      if (cmd_i.pop_load) begin
        right_q <= right_d;
      end
      if (cmd_i.key_next) begin
        key_idx_q <= key_idx_q + 1'b1;
      end
    end
  end

  // result register
  always_comb begin
    out_d = out_q;
    if (cmd_i.take) begin
      out_d.kind                = slsr_pkg::KIND_TX;
      out_d.tx_byte             = slsr_pkg::RSP_ACK;
      out_d.tx_last             = 1'b1;
      out_d.entry_present       = 1'b0;
      out_d.entry_op            = '0;
      out_d.entry_slot_or_param = '0;
      out_d.entry_value         = '0;
      out_d.pending_task        = is_task ? item_i.command : task_q;
      out_d.on_right            = right_q;
      out_d.queue_dropped       = is_change && q_full;
      if (is_idle && (task_q != 8'd0)) begin
        out_d.tx_byte = slsr_pkg::RSP_NACK;
      end
      if (is_key_req) begin
        out_d.tx_byte = slsr_pkg::HDR_KEY_STATE;
        out_d.tx_last = (key_count_q == '0);
      end
      if (item_i.action == slsr_pkg::ACT_POP) begin
        out_d.kind    = slsr_pkg::KIND_POP;
        out_d.tx_byte = '0;
        out_d.tx_last = 1'b0;
      end
    end
    if (cmd_i.pop_load) begin
      out_d.entry_present       = 1'b1;
      out_d.entry_op            = pop_op;
      out_d.entry_slot_or_param = pop_arg;
      out_d.entry_value         = pop_val;
      out_d.on_right            = right_d;
    end
    if (cmd_i.key_next) begin
      out_d.tx_byte = key_store_q[key_idx_q[KIW-1:0]];
      out_d.tx_last = ((key_idx_q + 1'b1) == key_count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_o = out_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCW'(QueueDepth))
    else $error("queue count beyond depth");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !q_full && !ram_re)
    else $error("queue written while full or popped");

  a_pop_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_load |-> $past(ram_re))
    else $error("pop result taken without a queue read");

  a_key_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.key_next |-> streaming_q && (key_idx_q < KCW'(KeyBytesMax)))
    else $error("key byte read out of range");
`endif

endmodule

>>> hw/rtl/split_link_slave_responder_core.sv
// timing: a reply beat is offered the cycle after its item is accepted, a pop report
// that finds an entry after the queue read state; a key-state reply is 1 + key count beats
// throughput: one item at a time, one beat a cycle while the sink takes them; the next item
// is taken the cycle after the last beat is taken, items without a reply send no beat
// reset: asynchronous, active low; slot counts 64, side index 0, queue empty, key bytes
// zero, left half; queue memory contents are not cleared
module split_link_slave_responder_core #(
  parameter int QueueDepth  = slsr_pkg::QUEUE_DEPTH,
  parameter int KeyBytesMax = slsr_pkg::KEY_BYTES_MAX
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [slsr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [slsr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // item and result channels
  slsr_in_if.sink                         in_chan,
  slsr_out_if.source                      out_chan
);

  // command and status between controller and datapath
  slsr_pkg::ctrl_cmd_t  cmd;
  slsr_pkg::dp_status_t status;

  // controller: idle / queue read / send beat
  slsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_chan.ready),
    .out_valid_o(out_chan.valid),
    .out_ready_i(out_chan.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: frame decode, task latch, key store, state-change queue,
  // result register that holds the current beat
  slsr_dp #(
    .QueueDepth (QueueDepth),
    .KeyBytesMax(KeyBytesMax)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (in_chan.data),
    .cmd_i      (cmd),
    .status_o   (status),
    .result_o   (out_chan.data)
  );

endmodule
